[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every edge outside reset
`define PES_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("scheduler assertion failed");

// property that only applies while a qualifying condition holds
`define PES_ASSERT_IF(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
    else $error("scheduler assertion failed");

`endif

[rtl/pes_pkg.sv]
// ----------------------------------------------------------------------------
// pes_pkg
// types and constants shared by the periodic event scheduler modules
// ----------------------------------------------------------------------------
package pes_pkg;

  // action codes carried on the input tuser
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // release limit per tick
  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned MW      = $clog2(MAX_OUT + 1);
  localparam logic [MW-1:0] MAX_OUT_C = MW'(MAX_OUT);

  // stream payload layout
  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_TUSER_W = 2;

  localparam int unsigned KIND_LSB   = 0;
  localparam int unsigned LEVEL_LSB  = 3;
  localparam int unsigned START_LSB  = 11;
  localparam int unsigned PERIOD_LSB = 43;
  localparam int unsigned NOW_LSB    = 75;

  typedef struct packed {
    logic [31:0] tstamp;
    logic [31:0] period;
    logic [2:0]  kind;
    logic [7:0]  level;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ROTATE = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      valid;
    logic      tail;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

endpackage

[rtl/pes_cell.sv]
// ----------------------------------------------------------------------------
// pes_cell
// one queue slot: holds an entry, sorted insert and rotate towards the head
// ----------------------------------------------------------------------------
module pes_cell (
  input  logic               clk_i,
  input  pes_pkg::cell_ctl_t ctl_i,
  input  logic               prev_after_i,
  input  pes_pkg::entry_t    new_entry_i,
  input  pes_pkg::entry_t    prev_entry_i,
  input  pes_pkg::entry_t    next_entry_i,
  input  pes_pkg::entry_t    wrap_entry_i,
  output pes_pkg::entry_t    entry_o,
  output logic               after_o
);
  import pes_pkg::*;

  entry_t entry_q, entry_d;

  // new entry goes behind every held entry with an equal or lower key
  assign after_o = ctl_i.valid &&
                   ({entry_q.kind, entry_q.level} <= {new_entry_i.kind, new_entry_i.level});

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (!after_o) begin
          entry_d = prev_after_i ? new_entry_i : prev_entry_i;
        end
      end
      CMD_ROTATE: begin
        entry_d = ctl_i.tail ? wrap_entry_i : next_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/periodic_event_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_event_scheduler_unit
// bounded queue of periodic release entries, released on matching ticks
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transfer per command. tuser selects insert, tick
// or clear; tdata carries the entry fields and the tick time.
// Output stream (m_axis): insert, clear and an idle tick give one result with
// tlast set; a tick gives one result per released entry, tlast on the final.
// Entries sit in a row of cells kept sorted by kind then level then age.
// Insert, clear and a tick on an empty queue go from idle straight to the
// response state, which loads the result register once it is free; the
// next transfer is taken only when the unit is back in idle.
// A tick on a filled queue rotates the row one cell per cycle: a first pass
// checks for passed times and counts due entries; if a time has passed or
// none is due it responds, else a second pass emits and reschedules them at
// the head, holding at a due entry while the result register is busy.
// The queue holds up to QUEUE_DEPTH entries; one command is in work at a time.
// A stalled receiver holds the output register; the second pass then waits
// at each due entry until the result register frees up.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared, only the fill count.
// ----------------------------------------------------------------------------
module periodic_event_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // kind, level, start_time, period, now, zero pad
  input  logic [pes_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // action
  input  logic [pes_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_kind, out_level, zero pad
  output logic [pes_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // released, status
  output logic [pes_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import pes_pkg::*;

  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  state_e        state_q, state_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          stale_q, stale_d;
  logic [MW-1:0] cnt_q, cnt_d;
  logic [MW-1:0] emit_q, emit_d;
  logic          stat_q, stat_d;
  logic [31:0]   now_q, now_d;

  logic          out_valid_q, out_valid_d;
  logic          out_rel_q, out_rel_d;
  logic [2:0]    out_kind_q, out_kind_d;
  logic [7:0]    out_level_q, out_level_d;
  logic          out_stat_q, out_stat_d;
  logic          out_last_q, out_last_d;

  entry_t    cell_entry [QUEUE_DEPTH];
  logic      cell_after [QUEUE_DEPTH];
  cell_ctl_t cell_ctl   [QUEUE_DEPTH];

  entry_t     new_entry, head, wrap_entry;
  logic [1:0] action;
  logic       accept, full, do_insert, head_due, release_en, rot_en, out_free, last_pos;
  logic       stale_n;
  logic [MW-1:0] cnt_n;
  cell_cmd_e  cmd;

  assign action           = s_axis_tuser_i;
  assign new_entry.kind   = s_axis_tdata_i[KIND_LSB +: 3];
  assign new_entry.level  = s_axis_tdata_i[LEVEL_LSB +: 8];
  assign new_entry.tstamp = s_axis_tdata_i[START_LSB +: 32];
  assign new_entry.period = s_axis_tdata_i[PERIOD_LSB +: 32];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (occ_q == OW'(QUEUE_DEPTH));
  assign do_insert       = accept && (action == ACT_INSERT) && !full;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign head       = cell_entry[0];
  assign head_due   = (head.tstamp == now_q);
  assign release_en = (state_q == ST_EMIT) && head_due && (emit_q != cnt_q);
  assign last_pos   = (pos_q == PW'(occ_q - OW'(1)));

  always_comb begin
    rot_en = 1'b0;
    case (state_q)
      ST_SCAN: rot_en = 1'b1;
      ST_EMIT: rot_en = !release_en || out_free;
      default: rot_en = 1'b0;
    endcase
  end

  // head goes round to the tail, rescheduled when it is released
  always_comb begin
    wrap_entry = head;
    if (release_en) begin
      wrap_entry.tstamp = now_q + head.period;
    end
  end

  assign cmd = do_insert ? CMD_INSERT : (rot_en ? CMD_ROTATE : CMD_HOLD);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].cmd   = cmd;
    assign cell_ctl[i].valid = (OW'(i) < occ_q);
    assign cell_ctl[i].tail  = (OW'(i) == occ_q - OW'(1));

    pes_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl[i]),
      .prev_after_i ((i == 0) ? 1'b1 : cell_after[(i == 0) ? 0 : i - 1]),
      .new_entry_i  (new_entry),
      .prev_entry_i ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .next_entry_i ((i == QUEUE_DEPTH - 1) ? wrap_entry :
                     cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .wrap_entry_i (wrap_entry),
      .entry_o      (cell_entry[i]),
      .after_o      (cell_after[i])
    );
  end

  // first pass tallies, due count saturates at the release limit
  assign stale_n = stale_q || (head.tstamp < now_q);
  assign cnt_n   = (head_due && (cnt_q != MAX_OUT_C)) ? cnt_q + MW'(1) : cnt_q;

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    pos_d   = pos_q;
    stale_d = stale_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    stat_d  = stat_q;
    now_d   = now_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          now_d   = s_axis_tdata_i[NOW_LSB +: 32];
          stat_d  = 1'b0;
          state_d = ST_RESP;
          case (action)
            ACT_INSERT: begin
              stat_d = full;
              if (!full) begin
                occ_d = occ_q + OW'(1);
              end
            end
            ACT_TICK: begin
              if (occ_q != '0) begin
                state_d = ST_SCAN;
                pos_d   = '0;
                stale_d = 1'b0;
                cnt_d   = '0;
              end
            end
            ACT_CLEAR: begin
              occ_d = '0;
            end
            default: begin
              stat_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        pos_d   = pos_q + PW'(1);
        stale_d = stale_n;
        cnt_d   = cnt_n;
        if (last_pos) begin
          pos_d  = '0;
          emit_d = '0;
          if (stale_n || (cnt_n == '0)) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (rot_en) begin
          pos_d = pos_q + PW'(1);
          if (release_en) begin
            emit_d = emit_q + MW'(1);
          end
          if (last_pos) begin
            pos_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_rel_d   = out_rel_q;
    out_kind_d  = out_kind_q;
    out_level_d = out_level_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (release_en && out_free) begin
      out_valid_d = 1'b1;
      out_rel_d   = 1'b1;
      out_kind_d  = head.kind;
      out_level_d = head.level;
      out_stat_d  = 1'b0;
      out_last_d  = (emit_q + MW'(1) == cnt_q);
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_d = 1'b1;
      out_rel_d   = 1'b0;
      out_kind_d  = '0;
      out_level_d = '0;
      out_stat_d  = stat_q;
      out_last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      pos_q       <= '0;
      stale_q     <= 1'b0;
      cnt_q       <= '0;
      emit_q      <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      stale_q     <= stale_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    out_rel_q   <= out_rel_d;
    out_kind_q  <= out_kind_d;
    out_level_q <= out_level_d;
    out_stat_q  <= out_stat_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - 11){1'b0}}, out_level_q, out_kind_q};
  assign m_axis_tuser_o  = {out_stat_q, out_rel_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/pes_checker.sv]
// ----------------------------------------------------------------------------
// pes_checker
// port-level checks on the result stream of the periodic event scheduler
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pes_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [pes_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  input logic [pes_pkg::M_TUSER_W-1:0] m_axis_tuser_i,
  input logic                          m_axis_tlast_i
);

  logic out_stall;
  logic in_seen;

  assign out_stall = m_axis_tvalid_i && !m_axis_tready_i;
  assign in_seen   = s_axis_tvalid_i && s_axis_tready_i;

  // a stalled result holds still
  `PES_ASSERT_IF(a_out_hold, clk_i, rst_ni, out_stall,
    ##1 (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) &&
         $stable(m_axis_tlast_i)))

  // a result that reports no release carries no kind or level
  `PES_ASSERT_IF(a_idle_zero, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tuser_i[0],
    m_axis_tdata_i == '0)

  // non-release results are always the only result of their command
  `PES_ASSERT_IF(a_idle_last, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tuser_i[0],
    m_axis_tlast_i)

  // a refused insert is never a release
  `PES_ASSERT_IF(a_full_norel, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i[1],
    !m_axis_tuser_i[0])

  // no new command is taken in the cycle after one was taken
  `PES_ASSERT_IF(a_one_cmd, clk_i, rst_ni, in_seen, ##1 !s_axis_tready_i)

endmodule

bind periodic_event_scheduler_unit pes_checker u_pes_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
